>>> hw/rtl/scurve_step_interval_generator_defines.svh
// Assertion macros shared by the S-curve step interval generator modules.
`ifndef SCURVE_STEP_INTERVAL_GENERATOR_DEFINES_SVH
`define SCURVE_STEP_INTERVAL_GENERATOR_DEFINES_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define SCSIG_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define SCSIG_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/scsig_pkg.sv
// Shared constants, codes and control structs of the S-curve step interval generator.
package scsig_pkg;

    localparam int unsigned IV_W   = 20;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned RAMP_W = 8;
    localparam int unsigned DIV_W  = 32;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_MIN    = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    localparam logic [1:0] DIV_X  = 2'd0;
    localparam logic [1:0] DIV_VS = 2'd1;
    localparam logic [1:0] DIV_VT = 2'd2;
    localparam logic [1:0] DIV_IV = 2'd3;

    localparam logic [DIV_W-1:0]  VEL_NUM     = 32'd4096000000;
    localparam logic [DIV_W-1:0]  V_FLOOR     = 32'd4096;
    localparam logic [IV_W:0]     START_EXTRA = 21'd600;
    localparam logic [CNT_W-1:0]  LONG_MOVE   = 32'd150;
    localparam logic [RAMP_W-1:0] RAMP_CAP    = 8'd100;
    localparam logic [RAMP_W-1:0] CONT_RAMP   = 8'd120;
    localparam logic [CNT_W-1:0]  ENDLESS     = 32'hFFFF_FFFF;
    localparam logic [17:0]       S_THREE     = 18'd196608;

    localparam logic [IV_W-1:0] TARGET_RST = 20'd1000;
    localparam logic [IV_W-1:0] MIN_RST    = 20'd50;
    localparam logic [IV_W-1:0] MAX_RST    = 20'd20000;
    localparam logic [RAMP_W-1:0] RAMP_RST = 8'd60;

    typedef struct packed {
        logic       load_in;
        logic       decode;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_cap;
        logic       mul_sq;
        logic       mul_s;
        logic       blend;
        logic       iv_small;
        logic       load_out;
    } scsig_cmd_t;

    typedef struct packed {
        logic need_curve;
        logic v_small;
        logic div_done;
        logic out_free;
    } scsig_sts_t;

endpackage

>>> hw/rtl/scsig_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`include "scurve_step_interval_generator_defines.svh"

module scsig_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [scsig_pkg::DIV_W-1:0]   dividend,
    input  logic [scsig_pkg::DIV_W-1:0]   divisor,
    output logic                          done,
    output logic [scsig_pkg::DIV_W-1:0]   quotient
);

    localparam int unsigned CNT_BITS = $clog2(scsig_pkg::DIV_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic [scsig_pkg::DIV_W:0]   rem_reg;
    logic [scsig_pkg::DIV_W-1:0] quo_reg;
    logic [scsig_pkg::DIV_W:0]   rem_shift;
    logic [scsig_pkg::DIV_W:0]   rem_next;
    logic                        q_bit;

    always_comb
    begin
        rem_shift = {rem_reg[scsig_pkg::DIV_W-1:0], quo_reg[scsig_pkg::DIV_W-1]};
        q_bit     = (rem_shift >= {1'b0, divisor});
        rem_next  = q_bit ? (rem_shift - {1'b0, divisor}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(scsig_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[scsig_pkg::DIV_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `SCSIG_IMPLIES(a_no_restart, start, !busy_reg, "divider started while busy")
    `SCSIG_IMPLIES(a_done_idle, done_reg, !busy_reg, "divider done while still iterating")

endmodule

>>> hw/rtl/scsig_dp.sv
// Datapath: configuration, motion state, S-curve arithmetic and the output register.
`include "scurve_step_interval_generator_defines.svh"

module scsig_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  scsig_pkg::scsig_cmd_t          cmd,
    output scsig_pkg::scsig_sts_t          sts,
    input  logic                           cfg_valid,
    input  logic [1:0]                     cfg_index,
    input  logic [scsig_pkg::IV_W-1:0]     cfg_data,
    input  logic [1:0]                     mode,
    input  logic [scsig_pkg::CNT_W-1:0]    step_count,
    input  logic                           direction_cw,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic                           step_pulse,
    output logic [scsig_pkg::IV_W-1:0]     next_interval_us,
    output logic                           moving,
    output logic                           move_done,
    output logic                           direction_out
);

    localparam int unsigned IV_W   = scsig_pkg::IV_W;
    localparam int unsigned CNT_W  = scsig_pkg::CNT_W;
    localparam int unsigned RAMP_W = scsig_pkg::RAMP_W;
    localparam int unsigned DIV_W  = scsig_pkg::DIV_W;

    function automatic logic [IV_W-1:0] clamp_iv(input logic [IV_W-1:0] v,
                                                 input logic [IV_W-1:0] lo,
                                                 input logic [IV_W-1:0] hi);
        logic [IV_W-1:0] r;
        r = (v < lo) ? lo : v;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

    // Configuration registers.
    logic [IV_W-1:0] tgt_reg, min_reg, max_reg;
    // Motion state.
    logic              run_reg, cont_reg, dir_reg;
    logic [CNT_W-1:0]  sl_reg, sd_reg;
    logic [RAMP_W-1:0] ru_reg, rd_reg;
    logic [IV_W-1:0]   si_reg;
    // Captured command.
    logic [1:0]        mode_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              cw_reg;
    // Result under construction.
    logic              pulse_reg, done_reg, need_reg;
    logic [IV_W-1:0]   next_reg;
    // Curve arithmetic.
    logic [RAMP_W-1:0] cur_reg, tot_reg;
    logic [15:0]       x_reg, x2_reg;
    logic [17:0]       s_reg;
    logic [DIV_W-1:0]  vs_reg, vt_reg, v_reg;
    // Output register.
    logic              out_valid_reg, o_pulse_reg, o_moving_reg, o_done_reg, o_dir_reg;
    logic [IV_W-1:0]   o_next_reg;

    logic [IV_W-1:0]   lo_lim, hi_lim, tgt_eff;
    logic [IV_W:0]     start_sum;
    logic [IV_W-1:0]   start_iv;
    logic [CNT_W-1:0]  sl_dec, sd_inc, cand_cur;
    logic [RAMP_W-1:0] cand_tot;
    logic              cand;

    logic              d_run, d_cont, d_dir, d_pulse, d_done, d_curve;
    logic [CNT_W-1:0]  d_sl, d_sd;
    logic [RAMP_W-1:0] d_ru, d_rd;
    logic [IV_W-1:0]   d_si, d_next;

    logic [DIV_W-1:0]  div_a, div_b, div_q;
    logic              div_done;
    logic [31:0]       sq_prod;
    logic [17:0]       three_minus;
    logic [33:0]       s_prod;
    logic              v_up;
    logic [DIV_W-1:0]  v_diff;
    logic [49:0]       b_prod;
    logic [33:0]       v_sum;

    assign lo_lim    = (min_reg == '0) ? IV_W'(1) : min_reg;
    assign hi_lim    = (max_reg == '0) ? IV_W'(1) : max_reg;
    assign tgt_eff   = clamp_iv(tgt_reg, lo_lim, hi_lim);
    assign start_sum = {1'b0, tgt_eff} + scsig_pkg::START_EXTRA;
    assign start_iv  = (start_sum > {1'b0, hi_lim}) ? hi_lim : start_sum[IV_W-1:0];
    assign sl_dec    = sl_reg - 1'b1;
    assign sd_inc    = sd_reg + 1'b1;

    // Decode one command against the present motion state.
    always_comb
    begin
        d_run    = run_reg;
        d_cont   = cont_reg;
        d_dir    = dir_reg;
        d_sl     = sl_reg;
        d_sd     = sd_reg;
        d_ru     = ru_reg;
        d_rd     = rd_reg;
        d_si     = si_reg;
        d_pulse  = 1'b0;
        d_next   = '0;
        d_done   = 1'b0;
        d_curve  = 1'b0;
        cand     = 1'b0;
        cand_cur = sd_inc;
        cand_tot = ru_reg;
        unique case (mode_reg)
            scsig_pkg::MODE_MOVE, scsig_pkg::MODE_RUN:
            begin
                d_dir  = cw_reg;
                d_cont = (mode_reg == scsig_pkg::MODE_RUN);
                d_sd   = '0;
                if (mode_reg == scsig_pkg::MODE_RUN)
                begin
                    d_sl = scsig_pkg::ENDLESS;
                    d_ru = scsig_pkg::CONT_RAMP;
                    d_rd = '0;
                end
                else
                begin
                    d_sl = cnt_reg;
                    if (cnt_reg > scsig_pkg::LONG_MOVE)
                    begin
                        d_ru = (cnt_reg[CNT_W-1:2] > (CNT_W-2)'(scsig_pkg::RAMP_CAP)) ?
                               scsig_pkg::RAMP_CAP : cnt_reg[RAMP_W+1:2];
                        d_rd = d_ru;
                    end
                    else
                    begin
                        d_ru = cnt_reg[RAMP_W:1];
                        d_rd = cnt_reg[RAMP_W-1:0] - cnt_reg[RAMP_W:1];
                    end
                end
                d_si   = start_iv;
                d_run  = (mode_reg == scsig_pkg::MODE_RUN) || (cnt_reg != '0);
                d_next = d_run ? start_iv : '0;
                d_done = !d_run;
            end
            scsig_pkg::MODE_STOP:
            begin
                d_run  = 1'b0;
                d_cont = 1'b0;
                d_sl   = '0;
                d_sd   = '0;
            end
            scsig_pkg::MODE_TICK:
            begin
                if (run_reg)
                begin
                    d_pulse = 1'b1;
                    d_next  = tgt_eff;
                    if (!cont_reg && sl_reg != '0 && sl_reg != scsig_pkg::ENDLESS)
                    begin
                        d_sd = sd_inc;
                        d_sl = sl_dec;
                        if (sd_inc < CNT_W'(ru_reg))
                        begin
                            cand = 1'b1;
                        end
                        else if (sl_dec <= CNT_W'(rd_reg))
                        begin
                            cand     = 1'b1;
                            cand_cur = sl_dec;
                            cand_tot = rd_reg;
                        end
                        if (sl_dec == '0)
                        begin
                            d_run  = 1'b0;
                            d_next = '0;
                            d_done = 1'b1;
                            cand   = 1'b0;
                        end
                    end
                    else if (cont_reg && sd_reg < CNT_W'(ru_reg))
                    begin
                        d_sd = sd_inc;
                        cand = 1'b1;
                    end
                end
            end
        endcase
        // Outside the ramp proper, or with equal end speeds, the target stands as is.
        d_curve = cand && cand_tot != '0 && cand_cur < CNT_W'(cand_tot) && si_reg != tgt_eff;
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            scsig_pkg::DIV_X:
            begin
                div_a = {8'b0, cur_reg, 16'b0};
                div_b = DIV_W'(tot_reg);
            end
            scsig_pkg::DIV_VS:
            begin
                div_a = scsig_pkg::VEL_NUM;
                div_b = DIV_W'(si_reg);
            end
            scsig_pkg::DIV_VT:
            begin
                div_a = scsig_pkg::VEL_NUM;
                div_b = DIV_W'(tgt_eff);
            end
            scsig_pkg::DIV_IV:
            begin
                div_a = scsig_pkg::VEL_NUM;
                div_b = v_reg;
            end
        endcase
    end

    scsig_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sq_prod     = x_reg * x_reg;
    assign three_minus = scsig_pkg::S_THREE - {1'b0, x_reg, 1'b0};
    assign s_prod      = x2_reg * three_minus;
    assign v_up        = (vt_reg >= vs_reg);
    assign v_diff      = v_up ? (vt_reg - vs_reg) : (vs_reg - vt_reg);
    assign b_prod      = s_reg * v_diff;
    // The blend rounds toward the start speed.
    assign v_sum       = v_up ? ({2'b0, vs_reg} + b_prod[49:16])
                              : ({2'b0, vs_reg} - b_prod[49:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg  <= scsig_pkg::TARGET_RST;
            min_reg  <= scsig_pkg::MIN_RST;
            max_reg  <= scsig_pkg::MAX_RST;
            run_reg  <= 1'b0;
            cont_reg <= 1'b0;
            dir_reg  <= 1'b1;
            sl_reg   <= '0;
            sd_reg   <= '0;
            ru_reg   <= scsig_pkg::RAMP_RST;
            rd_reg   <= scsig_pkg::RAMP_RST;
            si_reg   <= scsig_pkg::MAX_RST;
            need_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    scsig_pkg::REG_TARGET: tgt_reg <= cfg_data;
                    scsig_pkg::REG_MIN:    min_reg <= cfg_data;
                    scsig_pkg::REG_MAX:    max_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.decode)
            begin
                run_reg  <= d_run;
                cont_reg <= d_cont;
                dir_reg  <= d_dir;
                sl_reg   <= d_sl;
                sd_reg   <= d_sd;
                ru_reg   <= d_ru;
                rd_reg   <= d_rd;
                si_reg   <= d_si;
                need_reg <= d_curve;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            cnt_reg  <= step_count;
            cw_reg   <= direction_cw;
        end
        if (cmd.decode)
        begin
            pulse_reg <= d_pulse;
            next_reg  <= d_next;
            done_reg  <= d_done;
            cur_reg   <= cand_cur[RAMP_W-1:0];
            tot_reg   <= cand_tot;
        end
        if (cmd.div_cap)
        begin
            unique case (cmd.div_sel)
                scsig_pkg::DIV_X:  x_reg  <= div_q[15:0];
                scsig_pkg::DIV_VS: vs_reg <= div_q;
                scsig_pkg::DIV_VT: vt_reg <= div_q;
                scsig_pkg::DIV_IV: next_reg <= clamp_iv(div_q[IV_W-1:0], lo_lim, hi_lim);
            endcase
        end
        if (cmd.mul_sq)
        begin
            x2_reg <= sq_prod[31:16];
        end
        if (cmd.mul_s)
        begin
            s_reg <= s_prod[33:16];
        end
        if (cmd.blend)
        begin
            v_reg <= v_sum[DIV_W-1:0];
        end
        if (cmd.iv_small)
        begin
            next_reg <= hi_lim;
        end
        if (cmd.load_out)
        begin
            o_pulse_reg  <= pulse_reg;
            o_next_reg   <= next_reg;
            o_moving_reg <= run_reg;
            o_done_reg   <= done_reg;
            o_dir_reg    <= dir_reg;
        end
    end

    assign sts.need_curve = need_reg;
    assign sts.v_small    = (v_reg <= scsig_pkg::V_FLOOR);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid        = out_valid_reg;
    assign step_pulse       = o_pulse_reg;
    assign next_interval_us = o_next_reg;
    assign moving           = o_moving_reg;
    assign move_done        = o_done_reg;
    assign direction_out    = o_dir_reg;

    `SCSIG_IMPLIES(a_moving_rearms, out_valid_reg && o_moving_reg, o_next_reg != '0,
        "moving result without a next interval")
    `SCSIG_IMPLIES(a_done_stops, out_valid_reg && o_done_reg, !o_moving_reg,
        "finished move still reported as moving")

endmodule

>>> hw/rtl/scsig_ctrl.sv
// Controller: sequences command decode, the S-curve steps and the result beat.
`include "scurve_step_interval_generator_defines.svh"

module scsig_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  scsig_pkg::scsig_sts_t  sts,
    output scsig_pkg::scsig_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_ROUTE  = 4'd2;
    localparam logic [3:0] ST_XDIV   = 4'd3;
    localparam logic [3:0] ST_SQ     = 4'd4;
    localparam logic [3:0] ST_SCV    = 4'd5;
    localparam logic [3:0] ST_VSDIV  = 4'd6;
    localparam logic [3:0] ST_VTDIV  = 4'd7;
    localparam logic [3:0] ST_BLEND  = 4'd8;
    localparam logic [3:0] ST_IVDIV  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       go_reg, go_next;
    logic       div_en;
    logic [1:0] sel;
    logic [3:0] after;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        go_next    = go_reg;
        div_en     = 1'b0;
        sel        = scsig_pkg::DIV_X;
        after      = ST_OUT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                state_next = sts.need_curve ? ST_XDIV : ST_OUT;
            end
            ST_XDIV:
            begin
                div_en = 1'b1;
                sel    = scsig_pkg::DIV_X;
                after  = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = ST_SCV;
            end
            ST_SCV:
            begin
                cmd.mul_s  = 1'b1;
                state_next = ST_VSDIV;
            end
            ST_VSDIV:
            begin
                div_en = 1'b1;
                sel    = scsig_pkg::DIV_VS;
                after  = ST_VTDIV;
            end
            ST_VTDIV:
            begin
                div_en = 1'b1;
                sel    = scsig_pkg::DIV_VT;
                after  = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = ST_IVDIV;
            end
            ST_IVDIV:
            begin
                sel = scsig_pkg::DIV_IV;
                // At or below one step per second the longest interval is used directly.
                if (!go_reg && sts.v_small)
                begin
                    cmd.iv_small = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    div_en = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        cmd.div_sel = sel;
        if (div_en)
        begin
            if (!go_reg)
            begin
                cmd.div_start = 1'b1;
                go_next       = 1'b1;
            end
            else if (sts.div_done)
            begin
                cmd.div_cap = 1'b1;
                go_next     = 1'b0;
                state_next  = after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    `SCSIG_IMPLIES(a_done_in_div, sts.div_done,
        state_reg == ST_XDIV || state_reg == ST_VSDIV || state_reg == ST_VTDIV ||
        state_reg == ST_IVDIV, "divider finished outside a divide step")
    `SCSIG_IMPLIES(a_go_in_div, go_reg,
        state_reg == ST_XDIV || state_reg == ST_VSDIV || state_reg == ST_VTDIV ||
        state_reg == ST_IVDIV, "divide pending outside a divide step")

endmodule

>>> hw/rtl/scurve_step_interval_generator.sv
// Top level of the S-curve stepper step interval generator.
// Each input beat is one command (timer tick, counted move, continuous run or stop) and
// yields exactly one result beat. One command is in work at a time. A start, a stop, and
// a tick that needs no ramp point pass decode and route and go straight to the output
// step, and the next command is taken once the block is back in its idle state. A tick
// inside a ramp first runs the S-curve steps. The smoothstep point needs four divisions
// (ramp position, start speed, target speed, interval) on one shared radix-2 divider.
// Each division is a start step, 32 quotient bits and a done step. Two multiply steps
// follow the ramp position division and a blend follows the target speed division.
// When the blended speed is at or below one step per second the last division is
// skipped. A stalled result beat holds the block in its output step until the beat is
// taken. Configuration writes are taken at any time and should be made between commands.
module scurve_step_interval_generator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [scsig_pkg::CNT_W-1:0]        step_count,
    input  logic                               direction_cw,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               step_pulse,
    output logic [scsig_pkg::IV_W-1:0]         next_interval_us,
    output logic                               moving,
    output logic                               move_done,
    output logic                               direction_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [scsig_pkg::IV_W-1:0]         cfg_data
);

    scsig_pkg::scsig_cmd_t cmd;
    scsig_pkg::scsig_sts_t sts;

    assign cfg_ready = 1'b1;

    scsig_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    scsig_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .step_count       (step_count),
        .direction_cw     (direction_cw),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .step_pulse       (step_pulse),
        .next_interval_us (next_interval_us),
        .moving           (moving),
        .move_done        (move_done),
        .direction_out    (direction_out)
    );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the S-curve step interval generator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic                       pulse;
        logic [scsig_pkg::IV_W-1:0] interval;
        logic                       moving;
        logic                       done;
        logic                       dir;
    } step_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    mode;
    logic [scsig_pkg::CNT_W-1:0]   step_count;
    logic                          direction_cw;
    logic                          out_valid;
    logic                          out_stall;
    logic                          step_pulse;
    logic [scsig_pkg::IV_W-1:0]    next_interval_us;
    logic                          moving;
    logic                          move_done;
    logic                          direction_out;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index;
    logic [scsig_pkg::IV_W-1:0]    cfg_data;

    scurve_step_interval_generator DUT (.*);

    // Shadow copy of the block's registers and motion state.
    int unsigned    target_reg, min_reg, max_reg;
    bit             running, endless_run, dir_lvl;
    int unsigned    rem_steps, done_steps, up_len, down_len, launch_iv, cur_iv;

    step_result_t   expected_steps[$];
    int unsigned    mismatches;
    int unsigned    idle_cycles;
    int unsigned    send_idle_pct, recv_idle_pct;
    int unsigned    items_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned lo_limit();
        return (min_reg != 0) ? min_reg : 1;
    endfunction

    function automatic int unsigned hi_limit();
        return (max_reg != 0) ? max_reg : 1;
    endfunction

    function automatic int unsigned clamp_interval(int unsigned v);
        int unsigned r;
        r = v;
        if (r < lo_limit()) r = lo_limit();
        if (r > hi_limit()) r = hi_limit();
        return r;
    endfunction

    // Smoothstep blend in the velocity domain between start and target speeds.
    function automatic int unsigned ramp_interval(int unsigned cur, int unsigned total,
                                                  int unsigned si, int unsigned ti);
        longint unsigned x, x2, s, vs, vt, v, sdiv;
        sdiv = si;
        if (total == 0 || cur >= total) return ti;
        if (si == ti) return ti;
        if (sdiv == 0) sdiv = 1;
        x  = (longint'(cur) << 16) / total;
        x2 = (x * x) >> 16;
        s  = (x2 * (3 * 65536 - 2 * x)) >> 16;
        vs = 64'd4096000000 / sdiv;
        vt = 64'd4096000000 / ti;
        if (vt >= vs) v = vs + ((s * (vt - vs)) >> 16);
        else v = vs - ((s * (vs - vt)) >> 16);
        if (v <= 4096) return hi_limit();
        return clamp_interval(int'(64'd4096000000 / v));
    endfunction

    task automatic reset_shadow();
        target_reg = scsig_pkg::TARGET_RST;
        min_reg    = scsig_pkg::MIN_RST;
        max_reg    = scsig_pkg::MAX_RST;
        running    = 0;
        endless_run = 0;
        dir_lvl    = 1;
        rem_steps  = 0;
        done_steps = 0;
        up_len     = scsig_pkg::RAMP_RST;
        down_len   = scsig_pkg::RAMP_RST;
        launch_iv  = scsig_pkg::MAX_RST;
        cur_iv     = scsig_pkg::MAX_RST;
    endtask

    task automatic predict_step(logic [1:0] m, logic [scsig_pkg::CNT_W-1:0] n, logic cw);
        step_result_t r;
        int unsigned  t, nxt;
        r = '0;
        nxt = 0;
        t = clamp_interval(target_reg);
        if (m == scsig_pkg::MODE_MOVE || m == scsig_pkg::MODE_RUN) begin
            dir_lvl = cw;
            endless_run = (m == scsig_pkg::MODE_RUN);
            done_steps = 0;
            if (endless_run) begin
                rem_steps = scsig_pkg::ENDLESS;
                up_len = scsig_pkg::CONT_RAMP;
                down_len = 0;
            end else begin
                rem_steps = n;
                if (n > scsig_pkg::LONG_MOVE) begin
                    up_len = (n / 4 > scsig_pkg::RAMP_CAP) ? scsig_pkg::RAMP_CAP : n / 4;
                    down_len = up_len;
                end else begin
                    up_len = n / 2;
                    down_len = n - up_len;
                end
            end
            launch_iv = t + scsig_pkg::START_EXTRA;
            if (launch_iv > hi_limit()) launch_iv = hi_limit();
            cur_iv = launch_iv;
            running = endless_run || n != 0;
            if (running) nxt = launch_iv;
            else r.done = 1;
        end else if (m == scsig_pkg::MODE_STOP) begin
            running = 0;
            endless_run = 0;
            rem_steps = 0;
            done_steps = 0;
        end else if (running) begin
            r.pulse = 1;
            nxt = t;
            if (!endless_run && rem_steps != 0 && rem_steps != scsig_pkg::ENDLESS) begin
                done_steps++;
                rem_steps--;
                if (done_steps < up_len)
                    nxt = ramp_interval(done_steps, up_len, launch_iv, t);
                else if (rem_steps <= down_len)
                    nxt = ramp_interval(rem_steps, down_len, launch_iv, t);
                cur_iv = nxt;
                if (rem_steps == 0) begin
                    running = 0;
                    nxt = 0;
                    r.done = 1;
                end
            end else if (endless_run) begin
                if (done_steps < up_len) begin
                    done_steps++;
                    nxt = ramp_interval(done_steps, up_len, launch_iv, t);
                end
                cur_iv = nxt;
            end
            if (running) nxt = clamp_interval(nxt);
        end
        r.interval = nxt[scsig_pkg::IV_W-1:0];
        r.moving = running;
        r.dir = dir_lvl;
        expected_steps.push_back(r);
    endtask

    task automatic send_cmd(logic [1:0] m, logic [scsig_pkg::CNT_W-1:0] n, logic cw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        step_count   <= n;
        direction_cw <= cw;
        do @(posedge clk); while (in_stall);
        predict_step(m, n, cw);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [scsig_pkg::IV_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            scsig_pkg::REG_TARGET:
            begin
                target_reg = value;
                if (!running) cur_iv = clamp_interval(target_reg);
            end
            scsig_pkg::REG_MIN: min_reg = value;
            scsig_pkg::REG_MAX: max_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(int unsigned t, int unsigned lo, int unsigned hi);
        wait_drained();
        write_reg(scsig_pkg::REG_MIN, lo[scsig_pkg::IV_W-1:0]);
        write_reg(scsig_pkg::REG_MAX, hi[scsig_pkg::IV_W-1:0]);
        write_reg(scsig_pkg::REG_TARGET, t[scsig_pkg::IV_W-1:0]);
    endtask

    task automatic run_ticks(int unsigned k);
        repeat (k) send_cmd(scsig_pkg::MODE_TICK, $urandom(), $urandom_range(1));
    endtask

    task automatic test_directed_cases();
        send_cmd(scsig_pkg::MODE_TICK, '0, 1'b0);              // tick while idle
        send_cmd(scsig_pkg::MODE_STOP, '1, 1'b1);              // stop while idle
        send_cmd(scsig_pkg::MODE_MOVE, '0, 1'b0);              // zero-step move ends at once
        send_cmd(scsig_pkg::MODE_MOVE, 32'd1, 1'b1);           // single step is also the last
        run_ticks(2);
        send_cmd(scsig_pkg::MODE_MOVE, 32'd5, 1'b0);
        run_ticks(5);
        send_cmd(scsig_pkg::MODE_MOVE, scsig_pkg::ENDLESS, 1'b1); // all-ones count never ends
        run_ticks(3);
        send_cmd(scsig_pkg::MODE_STOP, '0, 1'b0);
        send_cmd(scsig_pkg::MODE_MOVE, 32'hFFFF_FFFE, 1'b0);   // longest counted move
        run_ticks(2);
        send_cmd(scsig_pkg::MODE_STOP, '0, 1'b0);
        send_cmd(scsig_pkg::MODE_RUN, '1, 1'b1);
        run_ticks(3);
        send_cmd(scsig_pkg::MODE_RUN, '0, 1'b0);               // restart while running
    endtask

    task automatic test_limit_extremes();
        set_limits(1048575, 1, 1048575);
        send_cmd(scsig_pkg::MODE_MOVE, 32'd4, 1'b1);
        run_ticks(4);
        set_limits(1, 1, 1048575);
        send_cmd(scsig_pkg::MODE_MOVE, 32'd6, 1'b0);
        run_ticks(6);
        set_limits(500, 2000, 100);                 // minimum above maximum
        send_cmd(scsig_pkg::MODE_RUN, '0, 1'b1);
        run_ticks(3);
        set_limits(0, 0, 0);                        // zero limits act as one
        run_ticks(2);
        send_cmd(scsig_pkg::MODE_STOP, '0, 1'b0);
        set_limits(scsig_pkg::TARGET_RST, scsig_pkg::MIN_RST, scsig_pkg::MAX_RST);
    endtask

    // Mostly well-formed moves with random lengths, plus some noise beats.
    task automatic test_random_motion(int unsigned quota);
        int unsigned goal, r, n, k;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_cmd($urandom_range(3), $urandom(), $urandom_range(1));
            end else if (r < 20) begin
                send_cmd(scsig_pkg::MODE_RUN, $urandom(), $urandom_range(1));
                run_ticks($urandom_range(1, 130));
                if ($urandom_range(1))
                    send_cmd(scsig_pkg::MODE_STOP, $urandom(), $urandom_range(1));
            end else begin
                k = $urandom_range(99);
                if (k < 5) n = 0;
                else if (k < 10) n = scsig_pkg::ENDLESS;
                else if (k < 18) n = $urandom();
                else n = $urandom_range(1, 200);
                send_cmd(scsig_pkg::MODE_MOVE, n, $urandom_range(1));
                if (n == 0) continue;
                if (n > 210) run_ticks($urandom_range(1, 8));
                else run_ticks(n + $urandom_range(1));
                if (n > 210 || $urandom_range(9) == 0)
                    send_cmd(scsig_pkg::MODE_STOP, $urandom(), $urandom_range(1));
            end
        end
    endtask

    // Receiver side: random stall, changed only at the falling edge.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        step_result_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{step_pulse, next_interval_us, moving, move_done, direction_out};
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %p", got);
            end else begin
                want = expected_steps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = scsig_pkg::MODE_TICK;
        step_count = '0;
        direction_cw = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = scsig_pkg::REG_TARGET;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        items_sent = 0;
        send_idle_pct = 26;
        recv_idle_pct = 49;
        reset_shadow();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_limit_extremes();
        test_random_motion(500);
        send_idle_pct = 49;
        recv_idle_pct = 26;
        set_limits($urandom_range(20, 3000), $urandom_range(1, 200),
                   $urandom_range(3000, 30000));
        test_random_motion(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(200, 100, 1048575);
        test_random_motion(500);

        wait_drained();
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> scurve_step_interval_generator.f
+incdir+hw/rtl
hw/rtl/scsig_pkg.sv
hw/rtl/scsig_div.sv
hw/rtl/scsig_dp.sv
hw/rtl/scsig_ctrl.sv
hw/rtl/scurve_step_interval_generator.sv
bench/testbench.sv
